[hw/rtl/wea_pkg.sv]
// Shared types, constants and helpers for the weekly event alarm table.
// No dependencies; every other source file but wea_ram imports this package.
package wea_pkg;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int LIGHT_COUNT_DEF = 32;
  localparam int MAX_RESULTS     = 32;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

  // Request opcodes
  localparam logic [1:0] OP_SCHED_ON  = 2'd0;
  localparam logic [1:0] OP_SCHED_OFF = 2'd1;
  localparam logic [1:0] OP_REMOVE    = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  // Status answers
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Day codes
  localparam logic [2:0] DAY_SUNDAY    = 3'd0;
  localparam logic [2:0] DAY_SATURDAY  = 3'd6;
  localparam logic [3:0] CODE_EVERY    = 4'd7;
  localparam logic [3:0] CODE_WEEKDAYS = 4'd8;
  localparam logic [3:0] CODE_WEEKEND  = 4'd9;

  // Work class decided by the front end
  typedef enum logic [1:0] {
    KIND_SCHED,
    KIND_REMOVE,
    KIND_TICK,
    KIND_REJECT
  } kind_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
    logic        turn_on;
    logic [2:0]  now_day;
    logic [10:0] now_minute;
  } cmd_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
    logic        turn_on;
  } entry_t;

  // Pending light command of a tick
  typedef struct packed {
    logic [7:0] light;
    logic       on;
  } hold_t;

  // Does a stored day code fire on the given day
  function automatic logic day_match(logic [3:0] code, logic [2:0] today);
    logic weekend;
    weekend = (today == DAY_SATURDAY) || (today == DAY_SUNDAY);
    return (code == CODE_EVERY) ||
           ((code == CODE_WEEKDAYS) && !weekend) ||
           ((code == CODE_WEEKEND) && weekend) ||
           (code == {1'b0, today});
  endfunction

endpackage

[hw/rtl/wea_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wea_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/wea_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on wea_pkg.
module wea_front import wea_pkg::*; #(
  parameter int LightCount = LIGHT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  light_id_i,
  input  logic [3:0]  day_code_i,
  input  logic [10:0] minute_i,
  input  logic [2:0]  now_day_i,
  input  logic [10:0] now_minute_i,
  output logic        q_vld_o,
  output cmd_t        q_cmd_o,
  input  logic        pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_w;
  logic       push_w;

  // Classify the incoming item
  always_comb begin
    cmd_w.light      = light_id_i;
    cmd_w.day        = day_code_i;
    cmd_w.minute     = minute_i;
    cmd_w.turn_on    = (opcode_i == OP_SCHED_ON);
    cmd_w.now_day    = now_day_i;
    cmd_w.now_minute = now_minute_i;
    unique case (opcode_i)
      OP_SCHED_ON, OP_SCHED_OFF: begin
        cmd_w.kind = ({1'b0, light_id_i} >= 9'(LightCount)) ? KIND_REJECT : KIND_SCHED;
      end
      OP_REMOVE: cmd_w.kind = KIND_REMOVE;
      OP_TICK:   cmd_w.kind = KIND_TICK;
      default:   cmd_w.kind = KIND_TICK;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push_w     = in_valid_i && !in_stall_o;
  assign q_vld_o    = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rd_ptr_q];

  // Two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push_w) begin
      mem_q[wr_ptr_q] <= cmd_w;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_w) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_w) - 2'(pop_i);
    end
  end

endmodule

[hw/rtl/wea_back.sv]
// Back end: scans the table one entry per cycle for schedule, remove and tick, unless a tick match stalls.
// Depends on wea_pkg and wea_ram.
module wea_back import wea_pkg::*; #(
  parameter int TableDepth = TABLE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_vld_i,
  input  cmd_t       q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic       has_command_o,
  output logic [7:0] cmd_light_o,
  output logic       cmd_on_o,
  output logic       last_o
);

  localparam int IW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TableDepth - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCHED  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  iss_q, iss_d;
  logic                  s2_vld_q, s2_vld_d;
  logic [IW-1:0]         s2_idx_q, s2_idx_d;
  logic [CNT_W-1:0]      n_q, n_d;
  hold_t                 hold_q, hold_d;
  logic                  hold_vld_q, hold_vld_d;
  cmd_t                  cmd_q, cmd_d;
  logic [1:0]            fin_q, fin_d;
  logic [TableDepth-1:0] valid_q, valid_d;

  logic                  out_vld_q, out_vld_d;
  logic [1:0]            out_status_q, out_status_d;
  logic                  out_has_q, out_has_d;
  logic [7:0]            out_light_q, out_light_d;
  logic                  out_on_q, out_on_d;
  logic                  out_last_q, out_last_d;

  logic                  we, re, can_push, tick_hit, rm_hit, stall_w;
  logic [$bits(entry_t)-1:0] rdata;
  entry_t                rd, wentry;

  assign wentry = '{light: cmd_q.light, day: cmd_q.day, minute: cmd_q.minute,
                    turn_on: cmd_q.turn_on};

  wea_ram #(
    .Width($bits(entry_t)),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign rd       = entry_t'(rdata);
  assign can_push = !out_vld_q || !out_stall_i;

  // Compare stage, one entry behind the read address
  assign tick_hit = s2_vld_q && (cmd_q.kind == KIND_TICK) && valid_q[s2_idx_q] &&
                    (rd.minute == cmd_q.now_minute) &&
                    day_match(rd.day, cmd_q.now_day) &&
                    (n_q < CNT_W'(MAX_RESULTS));
  assign rm_hit   = s2_vld_q && (cmd_q.kind == KIND_REMOVE) && valid_q[s2_idx_q] &&
                    (rd.light == cmd_q.light) && (rd.day == cmd_q.day) &&
                    (rd.minute == cmd_q.minute);
  // A new match needs the output slot when an older one is pending
  assign stall_w  = tick_hit && hold_vld_q && !can_push;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    iss_d        = iss_q;
    s2_vld_d     = s2_vld_q;
    s2_idx_d     = s2_idx_q;
    n_d          = n_q;
    hold_d       = hold_q;
    hold_vld_d   = hold_vld_q;
    cmd_d        = cmd_q;
    fin_d        = fin_q;
    valid_d      = valid_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_status_d = out_status_q;
    out_has_d    = out_has_q;
    out_light_d  = out_light_q;
    out_on_d     = out_on_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    we           = 1'b0;
    re           = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_vld_i) begin
          pop_o      = 1'b1;
          cmd_d      = q_cmd_i;
          idx_d      = '0;
          iss_d      = 1'b1;
          s2_vld_d   = 1'b0;
          n_d        = '0;
          hold_vld_d = 1'b0;
          fin_d      = STATUS_OK;
          unique case (q_cmd_i.kind)
            KIND_SCHED:  state_d = ST_SCHED;
            KIND_REJECT: begin
              fin_d   = STATUS_RANGE;
              state_d = ST_FINISH;
            end
            default:     state_d = ST_SCAN;
          endcase
        end
      end

      // First free slot search over the valid bits
      ST_SCHED: begin
        if (!valid_q[idx_q]) begin
          we             = 1'b1;
          valid_d[idx_q] = 1'b1;
          state_d        = ST_FINISH;
        end else if (idx_q == LAST_IDX) begin
          fin_d   = STATUS_FULL;
          state_d = ST_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Remove or tick scan through the RAM
      ST_SCAN: begin
        if (rm_hit) begin
          valid_d[s2_idx_q] = 1'b0;
        end
        if (tick_hit && !stall_w) begin
          if (hold_vld_q) begin
            out_vld_d    = 1'b1;
            out_status_d = STATUS_OK;
            out_has_d    = 1'b1;
            out_light_d  = hold_q.light;
            out_on_d     = hold_q.on;
            out_last_d   = 1'b0;
          end
          hold_d     = '{light: rd.light, on: rd.turn_on};
          hold_vld_d = 1'b1;
          n_d        = n_q + 1'b1;
        end
        if (!stall_w) begin
          s2_vld_d = iss_q;
          s2_idx_d = idx_q;
          if (iss_q) begin
            re    = 1'b1;
            idx_d = idx_q + 1'b1;
            if (idx_q == LAST_IDX) begin
              iss_d = 1'b0;
            end
          end
        end
        if (!iss_q && !s2_vld_q) begin
          state_d = ST_FINISH;
        end
      end

      // Final result of the item
      ST_FINISH: begin
        if (can_push) begin
          out_vld_d    = 1'b1;
          out_status_d = fin_q;
          out_has_d    = hold_vld_q;
          out_light_d  = hold_vld_q ? hold_q.light : 8'd0;
          out_on_d     = hold_vld_q && hold_q.on;
          out_last_d   = 1'b1;
          hold_vld_d   = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_q      <= 1'b0;
      s2_vld_q   <= 1'b0;
      hold_vld_q <= 1'b0;
      n_q        <= '0;
      valid_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_q      <= iss_d;
      s2_vld_q   <= s2_vld_d;
      hold_vld_q <= hold_vld_d;
      n_q        <= n_d;
      valid_q    <= valid_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    s2_idx_q     <= s2_idx_d;
    hold_q       <= hold_d;
    cmd_q        <= cmd_d;
    fin_q        <= fin_d;
    out_status_q <= out_status_d;
    out_has_q    <= out_has_d;
    out_light_q  <= out_light_d;
    out_on_q     <= out_on_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign has_command_o = out_has_q;
  assign cmd_light_o   = out_light_q;
  assign cmd_on_o      = out_on_q;
  assign last_o        = out_last_q;

  // At most one valid bit changes per cycle
  a_valid_one_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $onehot0(valid_q ^ $past(valid_q)))
    else $error("more than one table valid bit changed in a cycle");

  // Nothing left in flight when idle
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s2_vld_q && !hold_vld_q))
    else $error("idle with a compare or pending command left over");

  // Compare data must hold while the scan is stalled
  a_stall_holds_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_w |=> $stable(rdata))
    else $error("RAM read data moved during a stall");

  // Command count never passes the cap
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(MAX_RESULTS))
    else $error("tick command count above cap");

  // Finishing always leaves a last result in the output register
  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && can_push) |=> (out_vld_q && out_last_q))
    else $error("finish did not deliver a last result");

endmodule

[hw/rtl/weekly_event_alarm_table.sv]
// Weekly event alarm table: schedule, remove and minute-tick matching of light events.
// An out-of-range id answers without a scan and a schedule stops at the first free slot.
// A remove or tick scans every entry, one per cycle, through the single read port of the
// table RAM; a tick match waiting on a stalled result holds the scan. The back end takes
// one item at a time to its last result; a two-item queue buffers input.
// Reset clears all valid bits at once; no clearing pass is needed.
module weekly_event_alarm_table import wea_pkg::*; #(
  parameter int TableDepth = TABLE_DEPTH_DEF,
  parameter int LightCount = LIGHT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  light_id_i,
  input  logic [3:0]  day_code_i,
  input  logic [10:0] minute_i,
  input  logic [2:0]  now_day_i,
  input  logic [10:0] now_minute_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        has_command_o,
  output logic [7:0]  cmd_light_o,
  output logic        cmd_on_o,
  output logic        last_o
);

  logic q_vld, pop;
  cmd_t q_cmd;

  // Accept and classify
  wea_front #(
    .LightCount(LightCount)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .light_id_i   (light_id_i),
    .day_code_i   (day_code_i),
    .minute_i     (minute_i),
    .now_day_i    (now_day_i),
    .now_minute_i (now_minute_i),
    .q_vld_o      (q_vld),
    .q_cmd_o      (q_cmd),
    .pop_i        (pop)
  );

  // Table scan and results
  wea_back #(
    .TableDepth(TableDepth)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_vld_i       (q_vld),
    .q_cmd_i       (q_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .has_command_o (has_command_o),
    .cmd_light_o   (cmd_light_o),
    .cmd_on_o      (cmd_on_o),
    .last_o        (last_o)
  );

endmodule

[tb/sv/weekly_event_alarm_checker.sv]
// Checker for the weekly event alarm table: keeps its own copy of the event
// table, works out the answers and light commands for each accepted item and
// compares them with the results. Depends on wea_pkg for codes and sizes.
module weekly_event_alarm_checker
  import wea_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  light_id_i,
  input  logic [3:0]  day_code_i,
  input  logic [10:0] minute_i,
  input  logic [2:0]  now_day_i,
  input  logic [10:0] now_minute_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic        has_command_i,
  input  logic [7:0]  cmd_light_i,
  input  logic        cmd_on_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = TABLE_DEPTH_DEF;

  typedef struct {
    logic [1:0] status;
    logic       has_command;
    logic [7:0] light;
    logic       on;
    logic       last;
  } answer_t;

  // Mirror of the event table
  logic        slot_used   [Depth];
  logic [7:0]  slot_light  [Depth];
  logic [3:0]  slot_day    [Depth];
  logic [10:0] slot_minute [Depth];
  logic        slot_on     [Depth];

  // Answers and commands still owed by the block, oldest first
  answer_t answers_q[$];

  // Day code against the current day; day seven counts as a weekday
  function automatic logic fires_today(logic [3:0] code, logic [2:0] today);
    logic weekend;
    weekend = (today == DAY_SUNDAY) || (today == DAY_SATURDAY);
    case (code)
      CODE_EVERY:    return 1'b1;
      CODE_WEEKDAYS: return !weekend;
      CODE_WEEKEND:  return weekend;
      default:       return code == {1'b0, today};
    endcase
  endfunction

  function automatic void owe(logic [1:0] status, logic has, logic [7:0] light, logic on,
                              logic last);
    answer_t a;
    a.status      = status;
    a.has_command = has;
    a.light       = light;
    a.on          = on;
    a.last        = last;
    answers_q.push_back(a);
  endfunction

  // Apply one request to the mirror and queue what the block must answer
  function automatic void advance_schedule(logic [1:0] op, logic [7:0] light,
                                           logic [3:0] day, logic [10:0] minute,
                                           logic [2:0] today, logic [10:0] now_min);
    logic [1:0] status;
    int         hits;
    hits = 0;
    case (op)
      OP_SCHED_ON, OP_SCHED_OFF: begin
        status = STATUS_FULL;
        if (light >= LIGHT_COUNT_DEF) begin
          status = STATUS_RANGE;
        end else begin
          // lowest free slot wins
          for (int i = 0; i < Depth; i++) begin
            if (!slot_used[i]) begin
              slot_used[i]   = 1'b1;
              slot_light[i]  = light;
              slot_day[i]    = day;
              slot_minute[i] = minute;
              slot_on[i]     = (op == OP_SCHED_ON);
              status         = STATUS_OK;
              break;
            end
          end
        end
        owe(status, 1'b0, 8'd0, 1'b0, 1'b1);
      end
      OP_REMOVE: begin
        // every matching entry goes, ids are not range checked
        for (int i = 0; i < Depth; i++) begin
          if (slot_used[i] && slot_light[i] == light && slot_day[i] == day &&
              slot_minute[i] == minute) begin
            slot_used[i] = 1'b0;
          end
        end
        owe(STATUS_OK, 1'b0, 8'd0, 1'b0, 1'b1);
      end
      default: begin
        // minute tick: one command per match in table order, up to MAX_RESULTS
        for (int i = 0; i < Depth && hits < MAX_RESULTS; i++) begin
          if (slot_used[i] && slot_minute[i] == now_min && fires_today(slot_day[i], today)) begin
            owe(STATUS_OK, 1'b1, slot_light[i], slot_on[i], 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          owe(STATUS_OK, 1'b0, 8'd0, 1'b0, 1'b1);
        end else begin
          answers_q[answers_q.size() - 1].last = 1'b1;
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  // Watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
      answers_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        advance_schedule(opcode_i, light_id_i, day_code_i, minute_i, now_day_i, now_minute_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          $error("result with nothing expected: status %0d has_command %0d light %0d",
                 status_i, has_command_i, cmd_light_i);
          fail_count_o++;
        end else begin
          want = answers_q.pop_front();
          check_field("status", 8'(want.status), 8'(status_i));
          check_field("has_command", 8'(want.has_command), 8'(has_command_i));
          check_field("cmd_light", want.light, cmd_light_i);
          check_field("cmd_on", 8'(want.on), 8'(cmd_on_i));
          check_field("last", 8'(want.last), 8'(last_i));
        end
      end
    end
    pending_o = answers_q.size();
  end

endmodule

[tb/sv/weekly_event_alarm_table_tb.sv]
// Top of the weekly event alarm table testbench: clock, reset, request stimulus
// and result stalls, plus the verdict. Depends on wea_pkg, the block and
// weekly_event_alarm_checker, which does all prediction and comparison.
module weekly_event_alarm_table_tb import wea_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 300;

  typedef struct {
    logic [7:0]  light;
    logic [3:0]  day;
    logic [10:0] minute;
  } booking_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode     = OP_TICK;
  logic [7:0]  light_id   = 8'd0;
  logic [3:0]  day_code   = 4'd0;
  logic [10:0] minute     = 11'd0;
  logic [2:0]  now_day    = 3'd0;
  logic [10:0] now_minute = 11'd0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  status;
  logic        has_command;
  logic [7:0]  cmd_light;
  logic        cmd_on;
  logic        last;
  int          fail_count;
  int          pending;

  // Longest gap or stall per item; zero gives a stretch without idling
  int          idle_max     = 17;
  bit          hold_request = 1'b0;
  booking_t    booked_q[$];

  logic [10:0] minute_pool[6] = '{11'd0, 11'd1, 11'd600, 11'd1439, 11'd1440, 11'd2047};

  weekly_event_alarm_table u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .light_id_i    (light_id),
    .day_code_i    (day_code),
    .minute_i      (minute),
    .now_day_i     (now_day),
    .now_minute_i  (now_minute),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .has_command_o (has_command),
    .cmd_light_o   (cmd_light),
    .cmd_on_o      (cmd_on),
    .last_o        (last)
  );

  weekly_event_alarm_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .opcode_i      (opcode),
    .light_id_i    (light_id),
    .day_code_i    (day_code),
    .minute_i      (minute),
    .now_day_i     (now_day),
    .now_minute_i  (now_minute),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .has_command_i (has_command),
    .cmd_light_i   (cmd_light),
    .cmd_on_i      (cmd_on),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #5ns clk = ~clk;

  // Mostly lights in range, sometimes any id
  function automatic logic [7:0] pick_light();
    if ($urandom_range(99, 0) < 85) return 8'($urandom_range(LIGHT_COUNT_DEF - 1, 0));
    return 8'($urandom_range(255, 0));
  endfunction

  // Mostly valid day codes, sometimes codes above nine
  function automatic logic [3:0] pick_day();
    if ($urandom_range(99, 0) < 85) return 4'($urandom_range(9, 0));
    return 4'($urandom_range(15, 10));
  endfunction

  // A few shared minutes so that ticks and removes hit, else any value
  function automatic logic [10:0] pick_minute();
    if ($urandom_range(99, 0) < 80) return minute_pool[$urandom_range(5, 0)];
    return 11'($urandom_range(2047, 0));
  endfunction

  // Offer one item after a random gap and wait until it is taken
  task automatic send_item(logic [1:0] op, logic [7:0] light, logic [3:0] day,
                           logic [10:0] min, logic [2:0] today, logic [10:0] now_min);
    int gap;
    gap = $urandom_range(idle_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    light_id   <= light;
    day_code   <= day;
    minute     <= min;
    now_day    <= today;
    now_minute <= now_min;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic book_event(logic [1:0] op, logic [7:0] light, logic [3:0] day,
                            logic [10:0] min);
    booking_t b;
    send_item(op, light, day, min, 3'($urandom), 11'($urandom));
    if (light < LIGHT_COUNT_DEF) begin
      b.light  = light;
      b.day    = day;
      b.minute = min;
      booked_q.push_back(b);
    end
  endtask

  task automatic cancel_event(logic [7:0] light, logic [3:0] day, logic [10:0] min);
    send_item(OP_REMOVE, light, day, min, 3'($urandom), 11'($urandom));
  endtask

  task automatic clock_tick(logic [2:0] today, logic [10:0] now_min);
    send_item(OP_TICK, 8'($urandom), 4'($urandom), 11'($urandom), today, now_min);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Result side: random stall per result, or one long hold when asked
  initial begin : result_stall
    int pause;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        pause = $urandom_range(idle_max, 0);
        if (pause > 0) begin
          out_stall <= 1'b1;
          repeat (pause) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int       roll;
    int       idx;
    booking_t b;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, range checks, day codes, duplicates, removes
    clock_tick(3'd0, 11'd0);
    cancel_event(8'd255, 4'd15, 11'd2047);
    book_event(OP_SCHED_ON, 8'd32, 4'd1, 11'd100);
    book_event(OP_SCHED_OFF, 8'd255, 4'd2, 11'd100);
    book_event(OP_SCHED_ON, 8'd0, CODE_EVERY, 11'd0);
    book_event(OP_SCHED_OFF, 8'd31, CODE_WEEKDAYS, 11'd1439);
    book_event(OP_SCHED_ON, 8'd7, CODE_WEEKEND, 11'd2047);
    book_event(OP_SCHED_OFF, 8'd9, 4'd15, 11'd600);
    book_event(OP_SCHED_ON, 8'd2, 4'd3, 11'd600);
    book_event(OP_SCHED_ON, 8'd2, 4'd3, 11'd600);
    clock_tick(3'd7, 11'd0);
    clock_tick(3'd7, 11'd1439);
    clock_tick(3'd6, 11'd1439);
    clock_tick(3'd0, 11'd2047);
    clock_tick(3'd3, 11'd600);
    cancel_event(8'd2, 4'd3, 11'd600);
    clock_tick(3'd3, 11'd600);
    book_event(OP_SCHED_ON, 8'd3, 4'd0, 11'd5);
    clock_tick(3'd0, 11'd5);
    cancel_event(8'd0, CODE_EVERY, 11'd0);
    clock_tick(3'd1, 11'd0);

    // Random traffic with one fill-up episode in the middle
    for (int n = 0; n < 220; n++) begin
      if (n == 40) idle_max = 0;
      if (n == 80) idle_max = 17;
      if (n == 110) begin
        // empty the table, then fill it past full while results are held off
        drain();
        while (booked_q.size() > 0) begin
          b = booked_q.pop_front();
          cancel_event(b.light, b.day, b.minute);
        end
        hold_request = 1'b1;
        idle_max     = 0;
        for (int k = 0; k < TABLE_DEPTH_DEF + 2; k++) begin
          book_event($urandom_range(1, 0) ? OP_SCHED_OFF : OP_SCHED_ON,
                     8'($urandom_range(LIGHT_COUNT_DEF - 1, 0)), CODE_EVERY, 11'd777);
        end
        clock_tick(3'($urandom), 11'd777);
        idle_max = 17;
      end

      roll = $urandom_range(99, 0);
      if (roll < 30) begin
        book_event($urandom_range(1, 0) ? OP_SCHED_OFF : OP_SCHED_ON,
                   pick_light(), pick_day(), pick_minute());
      end else if (roll < 55) begin
        if (booked_q.size() > 0 && $urandom_range(4, 0) != 0) begin
          idx = $urandom_range(booked_q.size() - 1, 0);
          b   = booked_q[idx];
          booked_q.delete(idx);
          cancel_event(b.light, b.day, b.minute);
        end else begin
          cancel_event(8'($urandom), pick_day(), pick_minute());
        end
      end else begin
        if (booked_q.size() > 0 && $urandom_range(9, 0) < 6) begin
          idx = $urandom_range(booked_q.size() - 1, 0);
          clock_tick(3'($urandom), booked_q[idx].minute);
        end else begin
          clock_tick(3'($urandom), pick_minute());
        end
      end
    end

    // Let the last results out, then a margin for anything stray
    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("weekly_event_alarm_table_tb: PASS");
    end else begin
      $display("weekly_event_alarm_table_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #12ms;
    $display("weekly_event_alarm_table_tb: FAIL");
    $finish;
  end

endmodule

[weekly_event_alarm_table.f]
hw/rtl/wea_pkg.sv
hw/rtl/wea_ram.sv
hw/rtl/wea_front.sv
hw/rtl/wea_back.sv
hw/rtl/weekly_event_alarm_table.sv
tb/sv/weekly_event_alarm_checker.sv
tb/sv/weekly_event_alarm_table_tb.sv
